/* rtl/b64_pkg.sv */
// Shared types, constants and character mapping functions for the Base64 codec.
`default_nettype none
package b64_pkg;

  localparam logic [7:0] PAD_CHAR = 8'd61;
  localparam int         MAX_RES  = 4;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_END     = 2'd1,
    ST_BAD_PAD = 2'd2,
    ST_BAD_LEN = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    status_t    status;
    logic       last;
  } res_t;

  // Results of one request, entry 0 goes out first
  typedef struct packed {
    logic [2:0]              count;
    res_t [MAX_RES-1:0]      res;
  } burst_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)       return w + 8'd65;
    else if (v < 6'd52)  return w + 8'd71;
    else if (v < 6'd62)  return w - 8'd4;
    else if (v == 6'd62) return 8'd43;
    else                 return 8'd47;
  endfunction

  // Characters outside the alphabet map to zero
  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] w;
    w = 8'd0;
    if (c >= 8'd65 && c <= 8'd90)       w = c - 8'd65;
    else if (c >= 8'd97 && c <= 8'd122) w = c - 8'd71;
    else if (c >= 8'd48 && c <= 8'd57)  w = c + 8'd4;
    else if (c == 8'd43)                w = 8'd62;
    else if (c == 8'd47)                w = 8'd63;
    return w[5:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/base64_codec.sv */
// Base64 encoder/decoder (standard alphabet) with stream input and output.
// Slave channel: s_tdata carries one byte (raw data when encoding, ASCII text
// when decoding), s_tlast marks the last byte of a message.
// Master channel: m_tdata carries a Base64 character (encode) or a decoded
// byte (decode), m_tuser the status (0 data, 1 end marker without data,
// 2 bad padding, 3 bad length), m_tlast the final result of the message.
// cfg_we writes cfg_wdata to the direction bit (0 encode, 1 decode) and clears
// any partial group; write it only while the codec is idle.
// A request passes the input register and then the result register before
// its first result is on m_tdata. It yields 0 to 4 results, sent one per
// cycle from the result register while m_tready is high.
// The input register takes a new request while results still wait, and the
// result register reloads in the cycle its last result is taken.
// Reset clears the direction to encode and all group state. When the receiver
// stalls, results hold and s_tready drops once the input register is full.
`default_nettype none
module base64_codec (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // in_byte
  input  wire logic       s_tlast,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // out_byte
  output logic [1:0]      m_tuser,   // out_status
  output logic            m_tlast
);
  import b64_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       free;
  logic       load;
  burst_t     burst;

  assign load     = in_valid && free;
  assign s_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  b64_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (load),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .burst     (burst)
  );

  b64_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .burst_in (burst),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

/* rtl/b64_core.sv */
// Codec group state, direction register and per-request result generation.
`default_nettype none
module b64_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic            cfg_wdata,
  input  wire logic            step,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  output b64_pkg::burst_t      burst
);
  import b64_pkg::*;

  logic        direction;
  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic [1:0]  pad_seen;
  logic        skip_rest;

  logic [23:0] group_bits_next;
  logic [1:0]  group_count_next;
  logic [1:0]  pad_seen_next;
  logic        skip_rest_next;

  logic [23:0] enc_bits;
  logic [23:0] enc_v;
  logic [23:0] dec_bits;
  logic [1:0]  enc_cnt;
  logic [1:0]  skip_cnt;
  logic        is_pad;
  logic        bad;
  logic        ended;
  logic [2:0]  n;

  assign is_pad   = (in_byte == PAD_CHAR);
  assign enc_bits = {group_bits[15:0], in_byte};
  assign enc_cnt  = group_count + 2'd1;
  assign dec_bits = {group_bits[17:0], is_pad ? 6'd0 : char_value(in_byte)};
  assign skip_cnt = (pad_seen == 2'd3) ? group_count + 2'd1 : group_count;

  // Left-justify a short final group
  always_comb begin
    case (enc_cnt)
      2'd3:    enc_v = enc_bits;
      2'd2:    enc_v = {enc_bits[15:0], 8'd0};
      2'd1:    enc_v = {enc_bits[7:0], 16'd0};
      default: enc_v = 24'd0;
    endcase
  end

  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    pad_seen_next    = pad_seen;
    skip_rest_next   = skip_rest;
    bad              = 1'b0;
    ended            = 1'b0;
    n                = 3'd0;
    burst            = '0;

    if (!direction) begin
      group_bits_next  = enc_bits;
      group_count_next = enc_cnt;
      if (enc_cnt == 2'd3 || in_last) begin
        burst.res[0].data = sextet_char(enc_v[23:18]);
        burst.res[1].data = sextet_char(enc_v[17:12]);
        burst.res[2].data = (enc_cnt == 2'd1 || enc_cnt == 2'd0) ?
                            PAD_CHAR : sextet_char(enc_v[11:6]);
        burst.res[3].data = (enc_cnt == 2'd3) ? sextet_char(enc_v[5:0]) : PAD_CHAR;
        burst.res[3].last = in_last;
        n                 = 3'd4;
        group_bits_next   = 24'd0;
        group_count_next  = 2'd0;
      end
      if (in_last) begin
        pad_seen_next  = 2'd0;
        skip_rest_next = 1'b0;
      end
    end else if (skip_rest) begin
      group_count_next = skip_cnt;
      if (in_last) begin
        if (pad_seen == 2'd3) begin
          burst.res[0] = '{8'd0, (skip_cnt != 2'd0) ? ST_BAD_LEN : ST_END, 1'b1};
          n            = 3'd1;
        end
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
        pad_seen_next    = 2'd0;
        skip_rest_next   = 1'b0;
      end
    end else begin
      if (is_pad) begin
        if (group_count < 2'd2) begin
          bad = 1'b1;
        end else if (group_count == 2'd2) begin
          pad_seen_next    = 2'd1;
          group_bits_next  = dec_bits;
          group_count_next = 2'd3;
        end else begin
          burst.res[0].data = dec_bits[23:16];
          n                 = 3'd1;
          if (pad_seen != 2'd1) begin
            burst.res[1].data = dec_bits[15:8];
            n                 = 3'd2;
          end
          ended = 1'b1;
        end
      end else if (group_count == 2'd3 && pad_seen == 2'd1) begin
        bad = 1'b1;
      end else if (group_count == 2'd3) begin
        burst.res[0].data = dec_bits[23:16];
        burst.res[1].data = dec_bits[15:8];
        burst.res[2].data = dec_bits[7:0];
        n                 = 3'd3;
        group_bits_next   = 24'd0;
        group_count_next  = 2'd0;
      end else begin
        group_bits_next  = dec_bits;
        group_count_next = group_count + 2'd1;
      end

      if (bad) begin
        burst.res[0]     = '{8'd0, ST_BAD_PAD, 1'b1};
        n                = 3'd1;
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
        pad_seen_next    = 2'd0;
        skip_rest_next   = !in_last;
      end else if (ended) begin
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
        if (in_last) begin
          burst.res[n[1:0] - 2'd1].last = 1'b1;
          pad_seen_next  = 2'd0;
          skip_rest_next = 1'b0;
        end else begin
          // count the trailing text so the total length can be checked
          pad_seen_next  = 2'd3;
          skip_rest_next = 1'b1;
        end
      end else if (in_last) begin
        if (group_count_next != 2'd0) begin
          burst.res[n[1:0]] = '{8'd0, ST_BAD_LEN, 1'b1};
          n                 = n + 3'd1;
        end else if (n != 3'd0) begin
          burst.res[n[1:0] - 2'd1].last = 1'b1;
        end else begin
          burst.res[0] = '{8'd0, ST_END, 1'b1};
          n            = 3'd1;
        end
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
        pad_seen_next    = 2'd0;
        skip_rest_next   = 1'b0;
      end
    end

    burst.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= 1'b0;
      group_bits  <= 24'd0;
      group_count <= 2'd0;
      pad_seen    <= 2'd0;
      skip_rest   <= 1'b0;
    end else if (cfg_we) begin
      direction   <= cfg_wdata;
      group_bits  <= 24'd0;
      group_count <= 2'd0;
      pad_seen    <= 2'd0;
      skip_rest   <= 1'b0;
    end else if (step) begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      pad_seen    <= pad_seen_next;
      skip_rest   <= skip_rest_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/b64_burst.sv */
// Result register: holds one request's results, sent one per cycle on m_tready.
`default_nettype none
module b64_burst (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire b64_pkg::burst_t burst_in,
  output logic                 free,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);
  import b64_pkg::*;

  logic [2:0]         count;
  res_t [MAX_RES-1:0] entries;
  logic               take;

  assign m_tvalid = (count != 3'd0);
  assign take     = m_tvalid && m_tready;
  // Free when empty or once the last held result leaves in this cycle
  assign free     = (count == 3'd0) || (count == 3'd1 && m_tready);

  assign m_tdata = entries[0].data;
  assign m_tuser = entries[0].status;
  assign m_tlast = entries[0].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (load) begin
      count <= burst_in.count;
    end else if (take) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= burst_in.res;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        entries[i] <= entries[i+1];
      end
    end
  end

endmodule
`default_nettype wire

/* verif/tb_base64_codec.sv */
`timescale 1ns / 100ps
// Self-checking testbench for base64_codec: encode/decode streams against a local predictor.
module tb_base64_codec;
  import b64_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;   // in_byte
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // out_byte
  logic [1:0] m_tuser;          // out_status
  logic       m_tlast;

  base64_codec dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic        dir_mode = 1'b0;
  logic [23:0] grp_bits = '0;
  logic [1:0]  grp_cnt = '0;
  logic [1:0]  pad_state = '0;
  logic        dropping = 1'b0;

  res_t expected_q[$];
  int   errors = 0;
  int   accepted_cnt = 0;
  int   cycles = 0;
  int   rx_hold = 0;
  bit   calm = 1'b0;

  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    return ALPHABET[8*(63-v) +: 8];
  endfunction

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 6'(c - 8'd65);
    if (c >= "a" && c <= "z") return 6'(c - 8'd97 + 8'd26);
    if (c >= "0" && c <= "9") return 6'(c - 8'd48 + 8'd52);
    if (c == "+") return 6'd62;
    if (c == "/") return 6'd63;
    return 6'd0;
  endfunction

  function automatic int add_res(input logic [7:0] d, input status_t s, input logic l);
    res_t r;
    r.data = d;
    r.status = s;
    r.last = l;
    expected_q.push_back(r);
    return 1;
  endfunction

  function automatic void mark_last();
    res_t r;
    r = expected_q.pop_back();
    r.last = 1'b1;
    expected_q.push_back(r);
  endfunction

  function automatic void clear_group();
    grp_bits = '0;
    grp_cnt = '0;
    pad_state = '0;
    dropping = 1'b0;
  endfunction

  // Expected results of one accepted request; flags requests dropped after an error or end pad
  task automatic predict_codec(input logic [7:0] b, input logic l, output bit ignored);
    int          n;
    logic [23:0] v;
    logic [1:0]  p;
    bit          bad;
    bit          ended;
    n = 0;
    ignored = 1'b0;
    bad = 1'b0;
    ended = 1'b0;
    if (!dir_mode) begin
      grp_bits = {grp_bits[15:0], b};
      grp_cnt = grp_cnt + 2'd1;
      if (grp_cnt == 2'd3) begin
        n += add_res(alpha_char(grp_bits[23:18]), ST_DATA, 1'b0);
        n += add_res(alpha_char(grp_bits[17:12]), ST_DATA, 1'b0);
        n += add_res(alpha_char(grp_bits[11:6]), ST_DATA, 1'b0);
        n += add_res(alpha_char(grp_bits[5:0]), ST_DATA, 1'b0);
        grp_bits = '0;
        grp_cnt = '0;
      end else if (l) begin
        v = grp_bits << (8 * (3 - grp_cnt));
        n += add_res(alpha_char(v[23:18]), ST_DATA, 1'b0);
        n += add_res(alpha_char(v[17:12]), ST_DATA, 1'b0);
        if (grp_cnt == 2'd2) n += add_res(alpha_char(v[11:6]), ST_DATA, 1'b0);
        else n += add_res(PAD_CHAR, ST_DATA, 1'b0);
        n += add_res(PAD_CHAR, ST_DATA, 1'b0);
      end
      if (l) begin
        if (n > 0) mark_last();
        clear_group();
      end
    end else if (dropping) begin
      ignored = 1'b1;
      if (pad_state == 2'd3) grp_cnt = grp_cnt + 2'd1;
      if (l) begin
        // trailing text after a padded group: length decides the status
        if (pad_state == 2'd3) begin
          if (grp_cnt != 2'd0) n += add_res(8'd0, ST_BAD_LEN, 1'b1);
          else n += add_res(8'd0, ST_END, 1'b1);
        end
        clear_group();
      end
    end else begin
      p = grp_cnt;
      if (b == PAD_CHAR) begin
        if (p < 2'd2) begin
          bad = 1'b1;
        end else if (p == 2'd2) begin
          pad_state = 2'd1;
          grp_bits = {grp_bits[17:0], 6'd0};
          grp_cnt = 2'd3;
        end else begin
          grp_bits = {grp_bits[17:0], 6'd0};
          n += add_res(grp_bits[23:16], ST_DATA, 1'b0);
          if (pad_state != 2'd1) n += add_res(grp_bits[15:8], ST_DATA, 1'b0);
          ended = 1'b1;
        end
      end else if (p == 2'd3 && pad_state == 2'd1) begin
        bad = 1'b1;
      end else begin
        grp_bits = {grp_bits[17:0], sextet_of(b)};
        if (p == 2'd3) begin
          n += add_res(grp_bits[23:16], ST_DATA, 1'b0);
          n += add_res(grp_bits[15:8], ST_DATA, 1'b0);
          n += add_res(grp_bits[7:0], ST_DATA, 1'b0);
          grp_bits = '0;
          grp_cnt = '0;
        end else begin
          grp_cnt = p + 2'd1;
        end
      end

      if (bad) begin
        n += add_res(8'd0, ST_BAD_PAD, 1'b1);
        clear_group();
        if (!l) dropping = 1'b1;
      end else if (ended) begin
        clear_group();
        if (l) begin
          mark_last();
        end else begin
          dropping = 1'b1;
          pad_state = 2'd3;
        end
      end else if (l) begin
        if (grp_cnt != 2'd0) n += add_res(8'd0, ST_BAD_LEN, 1'b1);
        else if (n > 0) mark_last();
        else n += add_res(8'd0, ST_END, 1'b1);
        clear_group();
      end
    end
  endtask

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // result side: check every accepted result, then decide the next stall
  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: data %h status %0d last %0d",
                   m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (m_tdata !== want.data || m_tuser !== want.status || m_tlast !== want.last) begin
          if (errors < 10)
            $display("mismatch: expected data %h status %0d last %0d, got %h %0d %0d",
                     want.data, want.status, want.last, m_tdata, m_tuser, m_tlast);
          errors++;
        end
      end
    end
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (calm || $urandom_range(0, 99) < 70) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      rx_hold <= gap_len();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL base64_codec");
      $finish;
    end
  end

  task automatic send_req(input logic [7:0] b, input logic l);
    bit skipped;
    int gap;
    if (!s_tvalid) s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= l;
    do @(posedge clk); while (!s_tready);
    predict_codec(b, l, skipped);
    if (!skipped) accepted_cnt++;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_req(txt[i], i == txt.len() - 1);
  endtask

  // drain: all results in, then let the pipeline empty
  task automatic settle();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_direction(input logic d);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    dir_mode = d;
    clear_group();
  endtask

  task automatic test_encode_edges();
    write_direction(1'b0);
    send_req(8'h00, 1'b1);          // one byte: two pads
    send_req(8'hFF, 1'b0);          // two bytes: one pad
    send_req(8'hFF, 1'b1);
    send_req(8'hFB, 1'b0);          // full group that encodes to '++++'
    send_req(8'hEF, 1'b0);
    send_req(8'hBE, 1'b1);
  endtask

  task automatic test_decode_edges();
    write_direction(1'b1);
    send_text("+*/9");              // '*' is outside the alphabet
    send_text("=");                 // pad in first place
    send_text("Q");                 // short message
    send_text("QQ=xy");             // data after pad, then dropped
    send_text("QUI=abcd");          // trailing text of whole groups: end marker
  endtask

  task automatic send_encode_msg();
    int len;
    int r;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      send_req((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255)),
               i == len - 1);
    end
  endtask

  function automatic logic [7:0] any_char();
    return alpha_char(6'($urandom_range(0, 63)));
  endfunction

  task automatic send_decode_msg();
    logic [7:0] msg[$];
    int kind;
    int groups;
    int r;
    kind = $urandom_range(0, 9);
    groups = $urandom_range(0, 3);
    for (int g = 0; g < groups; g++)
      repeat (4) msg.push_back(any_char());
    case (kind)
      0, 1, 2, 3, 4, 5: begin
        r = $urandom_range(0, 2);
        if (r == 0 && groups == 0) repeat (4) msg.push_back(any_char());
        if (r == 1) begin
          repeat (2) msg.push_back(any_char());
          repeat (2) msg.push_back(PAD_CHAR);
        end
        if (r == 2) begin
          repeat (3) msg.push_back(any_char());
          msg.push_back(PAD_CHAR);
        end
      end
      6: begin
        repeat (2) msg.push_back(any_char());
        if ($urandom_range(0, 1)) msg.push_back(PAD_CHAR);
        else msg.push_back(any_char());
        msg.push_back(PAD_CHAR);
        repeat ($urandom_range(0, 7)) begin
          r = $urandom_range(0, 3);
          msg.push_back((r == 0) ? PAD_CHAR : (r == 1) ? 8'($urandom_range(0, 255))
                                                       : any_char());
        end
      end
      7: begin
        repeat ($urandom_range(1, 11)) begin
          if ($urandom_range(0, 4) == 0) msg.push_back(8'($urandom_range(0, 255)));
          else msg.push_back(any_char());
        end
      end
      8: begin
        repeat ($urandom_range(0, 1)) msg.push_back(any_char());
        msg.push_back(PAD_CHAR);
        repeat ($urandom_range(0, 4))
          msg.push_back($urandom_range(0, 2) == 0 ? PAD_CHAR : any_char());
      end
      default: begin
        repeat ($urandom_range(1, 8))
          msg.push_back($urandom_range(0, 3) == 0 ? PAD_CHAR : 8'($urandom_range(0, 255)));
      end
    endcase
    foreach (msg[i]) send_req(msg[i], i == msg.size() - 1);
  endtask

  task automatic test_random_traffic();
    logic dirs[6];
    int   start;
    dirs = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    for (int ph = 0; ph < 6; ph++) begin
      write_direction(dirs[ph]);
      calm = (ph == 2) || (ph == 4);
      start = accepted_cnt;
      while (accepted_cnt - start < 65) begin
        if (dir_mode) send_decode_msg();
        else send_encode_msg();
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_edges();
    test_decode_edges();
    test_random_traffic();
    settle();
    if (errors == 0 && expected_q.size() == 0) $display("PASS base64_codec");
    else $display("FAIL base64_codec");
    $finish;
  end

endmodule
